// ===== rtl/page_heap_first_fit_allocator_macros.svh =====
// Assertion macros for the page heap allocator.
// Used by the top level; no other dependencies.
`ifndef PAGE_HEAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define PAGE_HEAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PHFA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("phfa assertion failed");
`define PHFA_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("phfa assertion failed");
`else
`define PHFA_ASSERT(label, clk, rst_n, prop)
`define PHFA_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== rtl/phfa_pkg.sv =====
// Types, constants and helpers for the page heap allocator.
// No dependencies.
package phfa_pkg;
  localparam int PAGE_SIZE = 256;
  localparam int HDR_BYTES = 5;
  localparam int ADDR_W    = 8;
  localparam int SIZE_W    = 32;

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_FREE   = 3'd2;
  localparam logic [2:0] OP_LOCATE = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] request_size;
    logic [7:0] address;
    logic [5:0] block_index;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] block_offset;
    logic [7:0] block_size;
    logic [7:0] read_byte;
  } out_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
  } mem_req_t;

  localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(PAGE_SIZE - HDR_BYTES);

  function automatic logic [7:0] init_byte(input logic [ADDR_W-1:0] a);
    logic [7:0] b;
    b = 8'd0;
    if (int'(a) < HDR_BYTES - 1) begin
      b = INIT_SIZE[8*a[1:0] +: 8];
    end else if (int'(a) == HDR_BYTES - 1) begin
      b = 8'd1;
    end
    return b;
  endfunction
endpackage

// ===== rtl/phfa_mem.sv =====
// Page byte memory, one read and one write port, registered read data.
// Unwritten bytes read as the reset page image. Depends on phfa_pkg.
module phfa_mem (
  input  logic                clk,
  input  logic                rst_n,
  input  phfa_pkg::mem_req_t  req,
  output logic [7:0]          rdata
);
  localparam int DEPTH = phfa_pkg::PAGE_SIZE;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       data_r;
  logic [7:0]       init_r;
  logic             hit_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_r <= mem[req.rd_addr];
      init_r <= phfa_pkg::init_byte(req.rd_addr);
      hit_r  <= vld_r[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rdata = hit_r ? data_r : init_r;
endmodule

// ===== rtl/phfa_ctrl.sv =====
// Header walk sequencer: reads headers, decides, writes headers back.
// Depends on phfa_pkg; drives phfa_mem.
module phfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  phfa_pkg::in_t      in_data,
  input  logic               res_space,
  output logic               res_done,
  output phfa_pkg::out_t     res_data,
  output phfa_pkg::mem_req_t mreq,
  input  logic [7:0]         rdata
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HRD  = 4'd1;
  localparam logic [3:0] S_EVAL = 4'd2;
  localparam logic [3:0] S_NEVAL = 4'd3;
  localparam logic [3:0] S_FFIN = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_RDB  = 4'd6;
  localparam logic [3:0] S_RESP = 4'd7;

  localparam int SW = phfa_pkg::SIZE_W;
  localparam logic [SW+1:0] HB34  = (SW+2)'(phfa_pkg::HDR_BYTES);
  localparam logic [SW+1:0] LAST_HDR = (SW+2)'(phfa_pkg::PAGE_SIZE - phfa_pkg::HDR_BYTES);
  localparam logic [SW+1:0] PG34  = (SW+2)'(phfa_pkg::PAGE_SIZE);
  localparam logic [SW-1:0] HB32  = SW'(phfa_pkg::HDR_BYTES);
  localparam logic [7:0]    HB8   = 8'(phfa_pkg::HDR_BYTES);
  localparam logic [8:0]    HB9   = 9'(phfa_pkg::HDR_BYTES);
  localparam logic [2:0]    KLAST = 3'(phfa_pkg::HDR_BYTES);

  logic [3:0]    state_r, state_nxt;
  phfa_pkg::in_t op_r, op_nxt;
  logic [7:0]    h_r, h_nxt;
  logic [7:0]    rd_base_r, rd_base_nxt;
  logic [2:0]    k_r, k_nxt;
  logic          neigh_r, neigh_nxt;
  logic [SW-1:0] cur_size_r, cur_size_nxt;
  logic          cur_free_r, cur_free_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic [SW-1:0] prev_size_r, prev_size_nxt;
  logic          prev_free_r, prev_free_nxt;
  logic [SW-1:0] fsize_r, fsize_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic [7:0]    wr_base_r, wr_base_nxt;
  logic [SW-1:0] wr_size_r, wr_size_nxt;
  logic          wr_free_r, wr_free_nxt;
  logic          wr2_r, wr2_nxt;
  logic [7:0]    wr2_base_r, wr2_base_nxt;
  logic [SW-1:0] wr2_size_r, wr2_size_nxt;
  logic          wr2_free_r, wr2_free_nxt;
  phfa_pkg::out_t res_r, res_nxt;

  logic [SW+1:0] next34;
  logic          nfits;
  logic [8:0]    dpos;
  logic [SW-1:0] merged;

  assign in_ready = (state_r == S_IDLE);
  assign res_done = (state_r == S_RESP) && res_space;
  assign res_data = res_r;

  assign next34 = (SW+2)'(h_r) + HB34 + (SW+2)'(cur_size_r);
  assign nfits  = next34 <= LAST_HDR;
  assign dpos   = 9'(h_r) + HB9;
  assign merged = prev_size_r + HB32 + fsize_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    h_nxt         = h_r;
    rd_base_nxt   = rd_base_r;
    k_nxt         = k_r;
    neigh_nxt     = neigh_r;
    cur_size_nxt  = cur_size_r;
    cur_free_nxt  = cur_free_r;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    prev_size_nxt = prev_size_r;
    prev_free_nxt = prev_free_r;
    fsize_nxt     = fsize_r;
    cnt_nxt       = cnt_r;
    wr_base_nxt   = wr_base_r;
    wr_size_nxt   = wr_size_r;
    wr_free_nxt   = wr_free_r;
    wr2_nxt       = wr2_r;
    wr2_base_nxt  = wr2_base_r;
    wr2_size_nxt  = wr2_size_r;
    wr2_free_nxt  = wr2_free_r;
    res_nxt       = res_r;
    mreq          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_data;
          res_nxt       = '0;
          h_nxt         = 8'd0;
          rd_base_nxt   = 8'd0;
          k_nxt         = 3'd0;
          neigh_nxt     = 1'b0;
          have_prev_nxt = 1'b0;
          cnt_nxt       = 7'd0;
          case (in_data.opcode)
            phfa_pkg::OP_ALLOC, phfa_pkg::OP_FREE, phfa_pkg::OP_LOCATE: begin
              state_nxt = S_HRD;
            end
            phfa_pkg::OP_WRITE: begin
              mreq.wr_en     = 1'b1;
              mreq.wr_addr   = in_data.address;
              mreq.wr_data   = in_data.data_byte;
              res_nxt.status = phfa_pkg::ST_OK;
              state_nxt      = S_RESP;
            end
            phfa_pkg::OP_READ: begin
              mreq.rd_en   = 1'b1;
              mreq.rd_addr = in_data.address;
              state_nxt    = S_RDB;
            end
            default: begin
              res_nxt.status = phfa_pkg::ST_INVALID;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end
      S_RDB: begin
        res_nxt.status    = phfa_pkg::ST_OK;
        res_nxt.read_byte = rdata;
        state_nxt         = S_RESP;
      end
      S_HRD: begin
        if (k_r < KLAST) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = rd_base_r + 8'(k_r);
        end
        case (k_r)
          3'd1:    cur_size_nxt[7:0]   = rdata;
          3'd2:    cur_size_nxt[15:8]  = rdata;
          3'd3:    cur_size_nxt[23:16] = rdata;
          3'd4:    cur_size_nxt[31:24] = rdata;
          3'd5:    cur_free_nxt        = rdata != 8'd0;
          default: cur_size_nxt        = cur_size_r;
        endcase
        if (k_r == KLAST) begin
          k_nxt     = 3'd0;
          state_nxt = neigh_r ? S_NEVAL : S_EVAL;
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_EVAL: begin
        state_nxt   = S_HRD;
        h_nxt       = next34[7:0];
        rd_base_nxt = next34[7:0];
        case (op_r.opcode)
          phfa_pkg::OP_ALLOC: begin
            if (cur_free_r && ({1'b0, cur_size_r} > 33'(op_r.request_size) + 33'(HB32))
                && (next34 <= PG34)) begin
              wr_base_nxt  = h_r;
              wr_size_nxt  = SW'(op_r.request_size);
              wr_free_nxt  = 1'b0;
              wr2_nxt      = 1'b1;
              wr2_base_nxt = h_r + HB8 + op_r.request_size;
              wr2_size_nxt = cur_size_r - SW'(op_r.request_size) - HB32;
              wr2_free_nxt = 1'b1;
              res_nxt.status       = phfa_pkg::ST_OK;
              res_nxt.block_offset = h_r + HB8;
              res_nxt.block_size   = op_r.request_size;
              state_nxt            = S_WR;
            end else if (!nfits) begin
              res_nxt.status = phfa_pkg::ST_NOSPACE;
              state_nxt      = S_RESP;
            end
          end
          phfa_pkg::OP_LOCATE: begin
            if (!cur_free_r && cnt_r == {1'b0, op_r.block_index}) begin
              res_nxt.status       = phfa_pkg::ST_OK;
              res_nxt.block_offset = h_r + HB8;
              res_nxt.block_size   = cur_size_r[7:0];
              state_nxt            = S_RESP;
            end else begin
              if (!cur_free_r) begin
                cnt_nxt = cnt_r + 7'd1;
              end
              if (!nfits) begin
                res_nxt.status = phfa_pkg::ST_INVALID;
                state_nxt      = S_RESP;
              end
            end
          end
          default: begin
            if (dpos == 9'(op_r.address)) begin
              fsize_nxt = cur_size_r;
              h_nxt     = h_r;
              if (nfits) begin
                neigh_nxt = 1'b1;
              end else begin
                state_nxt = S_FFIN;
              end
            end else if (dpos > 9'(op_r.address) || !nfits) begin
              res_nxt.status = phfa_pkg::ST_INVALID;
              state_nxt      = S_RESP;
            end else begin
              prev_nxt      = h_r;
              have_prev_nxt = 1'b1;
              prev_size_nxt = cur_size_r;
              prev_free_nxt = cur_free_r;
            end
          end
        endcase
      end
      S_NEVAL: begin
        if (cur_free_r) begin
          fsize_nxt = fsize_r + HB32 + cur_size_r;
        end
        state_nxt = S_FFIN;
      end
      S_FFIN: begin
        wr_base_nxt    = h_r;
        wr_size_nxt    = fsize_r;
        wr_free_nxt    = 1'b1;
        res_nxt.status = phfa_pkg::ST_OK;
        state_nxt      = S_WR;
        if (have_prev_r && prev_free_r) begin
          wr2_nxt              = 1'b1;
          wr2_base_nxt         = prev_r;
          wr2_size_nxt         = merged;
          wr2_free_nxt         = 1'b1;
          res_nxt.block_offset = prev_r;
          res_nxt.block_size   = merged[7:0];
        end else begin
          wr2_nxt              = 1'b0;
          res_nxt.block_offset = h_r;
          res_nxt.block_size   = fsize_r[7:0];
        end
      end
      S_WR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = wr_base_r + 8'(k_r);
        case (k_r)
          3'd0:    mreq.wr_data = wr_size_r[7:0];
          3'd1:    mreq.wr_data = wr_size_r[15:8];
          3'd2:    mreq.wr_data = wr_size_r[23:16];
          3'd3:    mreq.wr_data = wr_size_r[31:24];
          default: mreq.wr_data = {7'd0, wr_free_r};
        endcase
        if (k_r == KLAST - 3'd1) begin
          k_nxt = 3'd0;
          if (wr2_r) begin
            wr2_nxt     = 1'b0;
            wr_base_nxt = wr2_base_r;
            wr_size_nxt = wr2_size_r;
            wr_free_nxt = wr2_free_r;
          end else begin
            state_nxt = S_RESP;
          end
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end
      S_RESP: begin
        if (res_space) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= 3'd0;
      wr2_r   <= 1'b0;
      neigh_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      wr2_r   <= wr2_nxt;
      neigh_r <= neigh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    h_r         <= h_nxt;
    rd_base_r   <= rd_base_nxt;
    cur_size_r  <= cur_size_nxt;
    cur_free_r  <= cur_free_nxt;
    prev_r      <= prev_nxt;
    have_prev_r <= have_prev_nxt;
    prev_size_r <= prev_size_nxt;
    prev_free_r <= prev_free_nxt;
    fsize_r     <= fsize_nxt;
    cnt_r       <= cnt_nxt;
    wr_base_r   <= wr_base_nxt;
    wr_size_r   <= wr_size_nxt;
    wr_free_r   <= wr_free_nxt;
    wr2_base_r  <= wr2_base_nxt;
    wr2_size_r  <= wr2_size_nxt;
    wr2_free_r  <= wr2_free_nxt;
    res_r       <= res_nxt;
  end
endmodule

// ===== rtl/page_heap_first_fit_allocator.sv =====
// Byte write goes to memory when accepted; byte read uses the registered read.
// Allocate/free/locate walk the headers, reading each byte by byte, then decide;
// free also reads the next neighbor; headers are then written back byte by byte.
// Throughput: one item at a time; the next is taken once the result is queued.
// The result register lets a new item start while the previous result waits.
// Reset (rst_n low, synchronous) restores one free block spanning the page.
`include "page_heap_first_fit_allocator_macros.svh"
module page_heap_first_fit_allocator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  phfa_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output phfa_pkg::out_t out_data
);
  phfa_pkg::mem_req_t mreq;
  logic [7:0]         rdata;
  logic               res_done;
  logic               res_space;
  phfa_pkg::out_t     res_data;
  logic               out_valid_r, out_valid_nxt;
  phfa_pkg::out_t     out_data_r, out_data_nxt;

  phfa_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rdata (rdata)
  );

  phfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_space (res_space),
    .res_done  (res_done),
    .res_data  (res_data),
    .mreq      (mreq),
    .rdata     (rdata)
  );

  assign res_space = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_done) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PHFA_ASSERT(a_done_space, clk, rst_n, res_done |-> (!out_valid_r || out_ready))
  `PHFA_ASSERT(a_busy_after, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
  `PHFA_ASSERT(a_status_code, clk, rst_n, out_valid_r |-> (out_data_r.status != 2'd3))
  `PHFA_ASSERT_NR(a_one_port, clk, !(mreq.rd_en && mreq.wr_en))
endmodule

// ===== sim/tb_page_heap_first_fit_allocator.sv =====
// Self-checking bench for the page heap first-fit allocator.
// Depends on phfa_pkg and the page_heap_first_fit_allocator top level.
module tb_page_heap_first_fit_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAGE = 256;
  localparam int HDR  = 5;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  phfa_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  phfa_pkg::out_t out_data;

  page_heap_first_fit_allocator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0] heap_page[PAGE];
  phfa_pkg::in_t  pending_ops[$];
  phfa_pkg::out_t expected_results[$];
  int   errors = 0;
  int   checked = 0;
  int   sent = 0;
  idle_mode_t idle_mode = IDLE_NONE;
  bit   hold_recv = 0;
  bit   pause_send = 0;
  int   n_nospace = 0, n_invalid = 0;

  function automatic bit hdr_fits(int h);
    return h + HDR <= PAGE;
  endfunction

  function automatic int hdr_size(int h);
    return {heap_page[h+3], heap_page[h+2], heap_page[h+1], heap_page[h]};
  endfunction

  function automatic bit hdr_is_free(int h);
    return heap_page[h+HDR-1] != 8'd0;
  endfunction

  function automatic void hdr_put(int h, int size, bit is_free);
    for (int k = 0; k < HDR - 1; k++) heap_page[h+k] = size[8*k +: 8];
    heap_page[h+HDR-1] = is_free ? 8'd1 : 8'd0;
  endfunction

  function automatic void heap_reset();
    for (int i = 0; i < PAGE; i++) heap_page[i] = 8'd0;
    hdr_put(0, PAGE - HDR, 1'b1);
  endfunction

  function automatic longint next_hdr(longint h);
    return h + HDR + longint'(unsigned'(hdr_size(int'(h))));
  endfunction

  function automatic phfa_pkg::out_t heap_apply(phfa_pkg::in_t op);
    phfa_pkg::out_t r;
    longint h, prev, s, n, res, cnt, sz;
    bit have_prev;
    r = '0;
    r.status = phfa_pkg::ST_INVALID;
    case (op.opcode)
      phfa_pkg::OP_ALLOC: begin
        r.status = phfa_pkg::ST_NOSPACE;
        for (h = 0; h + HDR <= PAGE; h = next_hdr(h)) begin
          s = longint'(unsigned'(hdr_size(int'(h))));
          if (hdr_is_free(int'(h)) && s > op.request_size + HDR && h + HDR + s <= PAGE) begin
            hdr_put(int'(h), op.request_size, 1'b0);
            hdr_put(int'(h + HDR + op.request_size), int'(s - op.request_size - HDR), 1'b1);
            r.status = phfa_pkg::ST_OK;
            r.block_offset = 8'(h + HDR);
            r.block_size = op.request_size;
            break;
          end
        end
      end
      phfa_pkg::OP_WRITE: begin
        heap_page[op.address] = op.data_byte;
        r.status = phfa_pkg::ST_OK;
      end
      phfa_pkg::OP_FREE: begin
        have_prev = 0;
        prev = 0;
        for (h = 0; h + HDR <= PAGE; h = next_hdr(h)) begin
          if (h + HDR == op.address) begin
            s = longint'(unsigned'(hdr_size(int'(h))));
            n = h + HDR + s;
            res = h;
            if (n + HDR <= PAGE && hdr_is_free(int'(n)))
              s = s + HDR + longint'(unsigned'(hdr_size(int'(n))));
            hdr_put(int'(h), int'(s), 1'b1);
            if (have_prev && hdr_is_free(int'(prev))) begin
              sz = longint'(unsigned'(hdr_size(int'(prev))));
              s = sz + HDR + s;
              hdr_put(int'(prev), int'(s), 1'b1);
              res = prev;
            end
            r.status = phfa_pkg::ST_OK;
            r.block_offset = 8'(res);
            r.block_size = 8'(s);
            break;
          end
          if (h + HDR > op.address) break;
          prev = h;
          have_prev = 1;
        end
      end
      phfa_pkg::OP_LOCATE: begin
        cnt = 0;
        for (h = 0; h + HDR <= PAGE; h = next_hdr(h)) begin
          if (!hdr_is_free(int'(h))) begin
            if (cnt == op.block_index) begin
              r.status = phfa_pkg::ST_OK;
              r.block_offset = 8'(h + HDR);
              r.block_size = 8'(hdr_size(int'(h)));
              break;
            end
            cnt++;
          end
        end
      end
      phfa_pkg::OP_READ: begin
        r.read_byte = heap_page[op.address];
        r.status = phfa_pkg::ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic phfa_pkg::in_t make_op(logic [2:0] opc, int req, int adr, int idx,
                                            int dat);
    phfa_pkg::in_t t;
    t.opcode = opc;
    t.request_size = 8'(req);
    t.address = 8'(adr);
    t.block_index = 6'(idx);
    t.data_byte = 8'(dat);
    return t;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d (transfer %0d)", what, got, want, checked);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_ready) begin
      // hold
    end else begin
      if (in_valid) begin
        expected_results.push_back(heap_apply(in_data));
        sent++;
      end
      if (pending_ops.size() > 0 && !pause_send &&
          !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
            $urandom_range(99, 0) < (idle_mode == IDLE_BOTH ? 26 : 81))) begin
        in_valid <= 1'b1;
        in_data <= pending_ops.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result transfer", 1, 0);
      end else begin
        phfa_pkg::out_t e;
        e = expected_results.pop_front();
        if (out_data.status != e.status) report_mismatch("status", out_data.status, e.status);
        if (out_data.block_offset != e.block_offset)
          report_mismatch("block_offset", out_data.block_offset, e.block_offset);
        if (out_data.block_size != e.block_size)
          report_mismatch("block_size", out_data.block_size, e.block_size);
        if (out_data.read_byte != e.read_byte)
          report_mismatch("read_byte", out_data.read_byte, e.read_byte);
        case (e.status)
          phfa_pkg::ST_NOSPACE: n_nospace++;
          phfa_pkg::ST_INVALID: n_invalid++;
          default: ;
        endcase
        checked++;
      end
    end
    if (hold_recv) begin
      out_ready <= 1'b0;
    end else if (idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) begin
      out_ready <= $urandom_range(99, 0) >= (idle_mode == IDLE_BOTH ? 26 : 81);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // candidate data offsets, set once at start, to bias frees toward likely blocks
  int live_offs[$];

  task automatic queue_random(int count);
    int c, a;
    for (int i = 0; i < count; i++) begin
      c = $urandom_range(99, 0);
      if (c < 32) begin
        a = ($urandom_range(9, 0) == 0) ? $urandom_range(255, 0) : $urandom_range(40, 0);
        pending_ops.push_back(make_op(phfa_pkg::OP_ALLOC, a, $urandom, $urandom, $urandom));
      end else if (c < 60) begin
        a = (live_offs.size() > 0 && $urandom_range(3, 0) != 0) ?
            live_offs[$urandom_range(live_offs.size() - 1, 0)] : $urandom_range(255, 0);
        pending_ops.push_back(make_op(phfa_pkg::OP_FREE, $urandom, a, $urandom, $urandom));
      end else if (c < 72) begin
        pending_ops.push_back(make_op(phfa_pkg::OP_LOCATE, $urandom, $urandom,
                                      $urandom_range(12, 0), $urandom));
      end else if (c < 80) begin
        pending_ops.push_back(make_op(phfa_pkg::OP_LOCATE, $urandom, $urandom, $urandom,
                                      $urandom));
      end else if (c < 88) begin
        pending_ops.push_back(make_op(phfa_pkg::OP_READ, $urandom, $urandom, $urandom,
                                      $urandom));
      end else if (c < 96) begin
        // occasional header corruption keeps walks honest
        a = (c < 90) ? $urandom_range(255, 0) : $urandom_range(255, 200);
        pending_ops.push_back(make_op(phfa_pkg::OP_WRITE, $urandom, a, $urandom, $urandom));
      end else begin
        pending_ops.push_back(make_op(3'($urandom_range(7, 5)), $urandom, $urandom,
                                      $urandom, $urandom));
      end
    end
  endtask

  task automatic drain;
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    #100000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    heap_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    for (int k = 0; k < 50; k++) live_offs.push_back(HDR + 5 * k + $urandom_range(40, 0));

    // directed
    pending_ops.push_back(make_op(phfa_pkg::OP_LOCATE, 0, 0, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_ALLOC, 255, 0, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_ALLOC, 245, 0, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_ALLOC, 0, 0, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_ALLOC, 10, 0, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_ALLOC, 20, 0, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_LOCATE, 0, 0, 2, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_LOCATE, 0, 0, 63, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_FREE, 0, 10, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_FREE, 0, 15, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_FREE, 0, 5, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_FREE, 0, 5, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_FREE, 0, 255, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_WRITE, 0, 0, 0, 8'hff));
    pending_ops.push_back(make_op(phfa_pkg::OP_WRITE, 0, 255, 0, 8'h00));
    pending_ops.push_back(make_op(phfa_pkg::OP_WRITE, 0, 8'haa, 0, 8'h55));
    pending_ops.push_back(make_op(phfa_pkg::OP_READ, 0, 0, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_READ, 0, 255, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_READ, 0, 8'haa, 0, 0));
    pending_ops.push_back(make_op(phfa_pkg::OP_LOCATE, 0, 0, 0, 0));
    pending_ops.push_back(make_op(3'd5, 0, 0, 0, 0));
    pending_ops.push_back(make_op(3'd7, 8'hff, 8'hff, 6'h3f, 8'hff));
    pending_ops.push_back(make_op(phfa_pkg::OP_WRITE, 0, 0, 0, 8'd0));
    pending_ops.push_back(make_op(phfa_pkg::OP_ALLOC, 8'd3, 0, 0, 0));
    drain();

    idle_mode = IDLE_NONE;
    queue_random(200);
    drain();
    idle_mode = IDLE_SEND;
    queue_random(200);
    drain();
    idle_mode = IDLE_RECV;
    queue_random(200);
    drain();

    // long receiver hold-off while the sender keeps offering
    idle_mode = IDLE_NONE;
    hold_recv = 1;
    queue_random(40);
    repeat (3000) @(posedge clk);
    hold_recv = 0;
    drain();

    // sender pause in mid-stream until everything is back
    queue_random(20);
    while (pending_ops.size() > 10) @(posedge clk);
    pause_send = 1;
    while (in_valid || expected_results.size() != 0) @(posedge clk);
    pause_send = 0;
    drain();

    idle_mode = IDLE_BOTH;
    queue_random(190);
    drain();
    repeat (500) @(posedge clk);

    $display("covered %0d sent and %0d checked transfers: %0d no-space, %0d invalid, rest ok",
             sent, checked, n_nospace, n_invalid);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
